/* rtl/core/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Field widths, the branch selector and the routing record that travels with
// each item through the root and divider pipelines.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Width of one matrix entry or one quaternion component.
    localparam int DATA_W = 16;
    // Number of matrix entries and quaternion components.
    localparam int MAT_N  = 9;
    localparam int QUAT_N = 4;
    // Magnitude of a sum or difference of two entries.
    localparam int MAG_W  = 17;
    // Quotient bits kept by the divider; larger quotients are flagged.
    localparam int QUO_W  = 17;
    // Number of sums or differences divided per item.
    localparam int DIV_N  = 3;

    // Which component comes from the square root.
    typedef enum logic [1:0] {
        SEL_W,
        SEL_X,
        SEL_Y,
        SEL_Z
    } sel_t;

    // Branch choice and the sign of each divided term.
    typedef struct packed {
        sel_t             sel;
        logic [DIV_N-1:0] neg;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

endpackage

/* rtl/core/rmq_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per register stage, restoring method; a sideband word travels
// alongside each item. All stages advance together on en.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
    parameter int ROOT_W = 17,
    parameter int SB_W   = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [SB_W-1:0]       in_sb,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SB_W-1:0]       out_sb
);

    localparam int REM_W = ROOT_W + 2;

    logic                valid_reg [0:ROOT_W-1];
    logic [2*ROOT_W-1:0] rad_reg   [0:ROOT_W-1];
    logic [REM_W-1:0]    rem_reg   [0:ROOT_W-1];
    logic [ROOT_W-1:0]   root_reg  [0:ROOT_W-1];
    logic [SB_W-1:0]     sb_reg    [0:ROOT_W-1];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic                v_in;
        logic [2*ROOT_W-1:0] rad_in;
        logic [REM_W-1:0]    rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [SB_W-1:0]     sb_in;
        logic [REM_W-1:0]    rem_sh;
        logic [REM_W-1:0]    trial;

        // Stage inputs come from the port or from the previous stage.
        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sb_in   = in_sb;
        end else begin : g_next
            assign v_in    = valid_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign sb_in   = sb_reg[i-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign rem_sh = {rem_in[REM_W-3:0], rad_in[2*ROOT_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= v_in;
            end
            if (en) begin
                rad_reg[i] <= rad_in << 2;
                sb_reg[i]  <= sb_in;
                if (rem_sh >= trial) begin
                    rem_reg[i]  <= rem_sh - trial;
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[i]  <= rem_sh;
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_sb    = sb_reg[ROOT_W-1];

endmodule

/* rtl/core/rmq_div3.sv */
// ----------------------------------------------------------------------------
// Pipelined triple divider
// Divides three magnitudes, scaled and rounded, by twice the root: one
// quotient bit per register stage for all three at once, with a flag for a
// quotient too large to keep.
// ----------------------------------------------------------------------------
module rmq_div3 #(
    parameter int FRAC_BITS = 14,
    parameter int ROOT_W    = 17,
    parameter int SB_W      = 8
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            en,
    input  logic                                            in_valid,
    input  logic [rmq_pkg::DIV_N-1:0][rmq_pkg::MAG_W-1:0]   in_mag,
    input  logic [ROOT_W-1:0]                               in_root,
    input  logic [SB_W-1:0]                                 in_sb,
    output logic                                            out_valid,
    output logic [rmq_pkg::DIV_N-1:0][rmq_pkg::QUO_W-1:0]   out_quo,
    output logic [rmq_pkg::DIV_N-1:0]                       out_ovf,
    output logic [ROOT_W-1:0]                               out_root,
    output logic [SB_W-1:0]                                 out_sb
);

    localparam int DN    = rmq_pkg::DIV_N;
    localparam int QW    = rmq_pkg::QUO_W;
    localparam int NUM_W = rmq_pkg::MAG_W + FRAC_BITS + 1;
    localparam int DEN_W = ROOT_W + 1;
    localparam int CMP_W = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

    // Setup stage: form the numerators and check for quotient overflow.
    logic                           pv_reg;
    logic [DN-1:0][CMP_W-1:0]       prem_reg;
    logic [DN-1:0]                  povf_reg;
    logic [DEN_W-1:0]               pden_reg;
    logic [ROOT_W-1:0]              proot_reg;
    logic [SB_W-1:0]                psb_reg;

    logic [DN-1:0][CMP_W-1:0]       num_next;
    logic [DN-1:0]                  ovf_next;
    logic [CMP_W-1:0]               den_top;

    always_comb begin
        den_top = CMP_W'({in_root, 1'b0}) << QW;
        for (int j = 0; j < DN; j++) begin
            num_next[j] = (CMP_W'(in_mag[j]) << FRAC_BITS) + CMP_W'(in_root);
            ovf_next[j] = (num_next[j] >= den_top);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= in_valid;
        end
        if (en) begin
            prem_reg  <= num_next;
            povf_reg  <= ovf_next;
            pden_reg  <= {in_root, 1'b0};
            proot_reg <= in_root;
            psb_reg   <= in_sb;
        end
    end

    // Long division stages, most significant quotient bit first.
    logic                      valid_reg [0:QW-1];
    logic [DN-1:0][CMP_W-1:0]  rem_reg   [0:QW-1];
    logic [DN-1:0][QW-1:0]     quo_reg   [0:QW-1];
    logic [DN-1:0]             ovf_reg   [0:QW-1];
    logic [DEN_W-1:0]          den_reg   [0:QW-1];
    logic [ROOT_W-1:0]         root_reg  [0:QW-1];
    logic [SB_W-1:0]           sb_reg    [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                     v_in;
        logic [DN-1:0][CMP_W-1:0] rem_in;
        logic [DN-1:0][QW-1:0]    quo_in;
        logic [DN-1:0]            ovf_in;
        logic [DEN_W-1:0]         den_in;
        logic [ROOT_W-1:0]        root_in;
        logic [SB_W-1:0]          sb_in;
        logic [CMP_W-1:0]         sub;
        logic [DN-1:0][CMP_W-1:0] rem_next;
        logic [DN-1:0][QW-1:0]    quo_next;

        if (k == 0) begin : g_first
            assign v_in    = pv_reg;
            assign rem_in  = prem_reg;
            assign quo_in  = '0;
            assign ovf_in  = povf_reg;
            assign den_in  = pden_reg;
            assign root_in = proot_reg;
            assign sb_in   = psb_reg;
        end else begin : g_next
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign ovf_in  = ovf_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sb_in   = sb_reg[k-1];
        end

        // Trial subtraction of the shifted divisor for each term.
        always_comb begin
            sub = CMP_W'(den_in) << (QW - 1 - k);
            for (int j = 0; j < DN; j++) begin
                if (rem_in[j] >= sub) begin
                    rem_next[j] = rem_in[j] - sub;
                    quo_next[j] = {quo_in[j][QW-2:0], 1'b1};
                end else begin
                    rem_next[j] = rem_in[j];
                    quo_next[j] = {quo_in[j][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                ovf_reg[k]  <= ovf_in;
                den_reg[k]  <= den_in;
                root_reg[k] <= root_in;
                sb_reg[k]   <= sb_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_ovf   = ovf_reg[QW-1];
    assign out_root  = root_reg[QW-1];
    assign out_sb    = sb_reg[QW-1];

endmodule

/* rtl/core/rotation_matrix_to_quaternion_top.sv */
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion (Shepperd's method), fixed point
//
// The slave channel takes one 3x3 matrix per item, nine signed entries with
// FRAC_BITS fraction bits. The master channel gives one quaternion item
// (w, x, y, z) per matrix, same format, saturated to plus or minus one.
// Items come out in the order they went in.
//
// Throughput is one item per cycle while the receiver does not stall. The
// input register loads at the accepting edge, and the result then passes
// one stage per root bit in the square root, a setup stage and one
// stage per quotient bit (17) in the divider, and the output register.
// ROOT_W is half the radicand width, 17 at FRAC_BITS = 14.
//
// Reset empties every pipeline stage and the output register. When the
// receiver stalls, the whole pipeline holds and s_tready falls while the
// output register is full, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
    input  logic [143:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // quat_w, quat_x, quat_y, quat_z, 16 bits each
    output logic [63:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready
);

    localparam int DW     = rmq_pkg::DATA_W;
    localparam int MW     = rmq_pkg::MAG_W;
    localparam int QW     = rmq_pkg::QUO_W;
    localparam int DN     = rmq_pkg::DIV_N;
    // Signed width of the radicand before clamping.
    localparam int SA_W   = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
    localparam int RADW   = SA_W - 1 + FRAC_BITS;
    localparam int ROOT_W = (RADW + 1) / 2;
    localparam int SB1_W  = rmq_pkg::ROUTE_W + DN * MW;
    localparam int SB2_W  = rmq_pkg::ROUTE_W;
    localparam logic [31:0] LIM = (FRAC_BITS < 15) ? (32'd1 << FRAC_BITS) : 32'd32767;
    localparam logic signed [SA_W-1:0] ONE_V = SA_W'(1) << FRAC_BITS;

    logic en;

    // ---------------- Input stage: branch choice, radicand, terms ----------
    logic signed [DW-1:0] m [0:rmq_pkg::MAT_N-1];
    for (genvar e = 0; e < rmq_pkg::MAT_N; e++) begin : g_unpack
        assign m[e] = s_tdata[e*DW +: DW];
    end

    logic signed [SA_W-1:0]   e00, e11, e22, tr, rad_s;
    logic [SA_W-2:0]          rad_u;
    logic signed [MW:0]       d_a, d_b, d_c;
    rmq_pkg::route_t          route_next;
    logic [DN-1:0][MW-1:0]    mag_next;

    always_comb begin
        e00 = SA_W'(m[0]);
        e11 = SA_W'(m[4]);
        e22 = SA_W'(m[8]);
        tr  = e00 + e11 + e22;
        if (tr > 0) begin
            route_next.sel = rmq_pkg::SEL_W;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            route_next.sel = rmq_pkg::SEL_X;
        end else if (m[4] > m[8]) begin
            route_next.sel = rmq_pkg::SEL_Y;
        end else begin
            route_next.sel = rmq_pkg::SEL_Z;
        end
        unique case (route_next.sel)
            rmq_pkg::SEL_W: begin
                rad_s = ONE_V + tr;
                d_a = (MW+1)'(m[7]) - (MW+1)'(m[5]);
                d_b = (MW+1)'(m[2]) - (MW+1)'(m[6]);
                d_c = (MW+1)'(m[3]) - (MW+1)'(m[1]);
            end
            rmq_pkg::SEL_X: begin
                rad_s = ONE_V + e00 - e11 - e22;
                d_a = (MW+1)'(m[1]) + (MW+1)'(m[3]);
                d_b = (MW+1)'(m[2]) + (MW+1)'(m[6]);
                d_c = (MW+1)'(m[7]) - (MW+1)'(m[5]);
            end
            rmq_pkg::SEL_Y: begin
                rad_s = ONE_V + e11 - e00 - e22;
                d_a = (MW+1)'(m[1]) + (MW+1)'(m[3]);
                d_b = (MW+1)'(m[5]) + (MW+1)'(m[7]);
                d_c = (MW+1)'(m[2]) - (MW+1)'(m[6]);
            end
            default: begin
                rad_s = ONE_V + e22 - e00 - e11;
                d_a = (MW+1)'(m[2]) + (MW+1)'(m[6]);
                d_b = (MW+1)'(m[5]) + (MW+1)'(m[7]);
                d_c = (MW+1)'(m[3]) - (MW+1)'(m[1]);
            end
        endcase
        // A radicand that is not positive is raised to one LSB.
        rad_u = (rad_s < 1) ? (SA_W-1)'(1) : rad_s[SA_W-2:0];
        route_next.neg = {d_c[MW], d_b[MW], d_a[MW]};
        mag_next[0] = d_a[MW] ? MW'(-d_a) : d_a[MW-1:0];
        mag_next[1] = d_b[MW] ? MW'(-d_b) : d_b[MW-1:0];
        mag_next[2] = d_c[MW] ? MW'(-d_c) : d_c[MW-1:0];
    end

    logic                    iv_reg;
    logic [2*ROOT_W-1:0]     irad_reg;
    logic [SB1_W-1:0]        isb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iv_reg <= 1'b0;
        end else if (en) begin
            iv_reg <= s_tvalid;
        end
        if (en) begin
            irad_reg <= (2*ROOT_W)'(rad_u) << FRAC_BITS;
            isb_reg  <= {route_next, mag_next};
        end
    end

    // ---------------- Square root ------------------------------------------
    logic                sq_valid;
    logic [ROOT_W-1:0]   sq_root;
    logic [SB1_W-1:0]    sq_sb;

    rmq_sqrt #(
        .ROOT_W (ROOT_W),
        .SB_W   (SB1_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (iv_reg),
        .in_rad    (irad_reg),
        .in_sb     (isb_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb)
    );

    // ---------------- Division by twice the root ---------------------------
    logic                       dv_valid;
    logic [DN-1:0][QW-1:0]      dv_quo;
    logic [DN-1:0]              dv_ovf;
    logic [ROOT_W-1:0]          dv_root;
    logic [SB2_W-1:0]           dv_sb;

    rmq_div3 #(
        .FRAC_BITS (FRAC_BITS),
        .ROOT_W    (ROOT_W),
        .SB_W      (SB2_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_mag    (sq_sb[DN*MW-1:0]),
        .in_root   (sq_root),
        .in_sb     (sq_sb[SB1_W-1 -: SB2_W]),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_ovf   (dv_ovf),
        .out_root  (dv_root),
        .out_sb    (dv_sb)
    );

    // ---------------- Half root, signs, saturation, routing ----------------
    rmq_pkg::route_t       fin_route;
    logic [ROOT_W:0]       hr_sum;
    logic [31:0]           hr_ext;
    logic [DW-1:0]         hr_sat;
    logic [DN-1:0][DW-1:0] term;
    logic [DW-1:0]         qw_v, qx_v, qy_v, qz_v;

    always_comb begin
        fin_route = rmq_pkg::route_t'(dv_sb);
        hr_sum = {1'b0, dv_root} + (ROOT_W+1)'(1);
        hr_ext = 32'(hr_sum[ROOT_W:1]);
        hr_sat = (hr_ext > LIM) ? LIM[DW-1:0] : hr_ext[DW-1:0];
        for (int j = 0; j < DN; j++) begin
            if (dv_ovf[j] || 32'(dv_quo[j]) > LIM) begin
                term[j] = LIM[DW-1:0];
            end else begin
                term[j] = dv_quo[j][DW-1:0];
            end
            if (fin_route.neg[j]) begin
                term[j] = -term[j];
            end
        end
        unique case (fin_route.sel)
            rmq_pkg::SEL_W: begin
                qw_v = hr_sat;  qx_v = term[0]; qy_v = term[1]; qz_v = term[2];
            end
            rmq_pkg::SEL_X: begin
                qx_v = hr_sat;  qy_v = term[0]; qz_v = term[1]; qw_v = term[2];
            end
            rmq_pkg::SEL_Y: begin
                qx_v = term[0]; qy_v = hr_sat;  qz_v = term[1]; qw_v = term[2];
            end
            default: begin
                qx_v = term[0]; qy_v = term[1]; qz_v = hr_sat;  qw_v = term[2];
            end
        endcase
    end

    // ---------------- Output register and flow control ---------------------
    logic        ov_reg;
    logic [63:0] odata_reg;

    // The pipeline moves whenever the output register is empty or being taken.
    assign en       = !ov_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= dv_valid;
        end
        if (en) begin
            odata_reg <= {qz_v, qy_v, qx_v, qw_v};
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = odata_reg;

endmodule
